// ----- hw/rtl/fresnel_reflectance_core_macros.svh -----
`ifndef FRESNEL_REFLECTANCE_CORE_MACROS_SVH
`define FRESNEL_REFLECTANCE_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge and idle in reset.
`define FRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define FRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/frc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package frc_pkg;

  // Field widths.
  localparam int unsigned IdxW  = 16;
  localparam int unsigned CosW  = 17;
  localparam int unsigned CodeW = 3;

  // Stream data widths, padded to whole bytes.
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned OutUserW = 8;

  // Square root radicand (up to 2^32) and divider widths.
  localparam int unsigned RadW  = 33;
  localparam int unsigned DendW = 51;
  localparam int unsigned DsorW = 34;
  localparam int unsigned QuoW  = 17;

  // One result bit is resolved per stage.
  localparam int unsigned SqStages  = 17;
  localparam int unsigned DivStages = 17;

  localparam logic [CosW-1:0] FullScale = 17'h10000;
  localparam logic [RadW-1:0] OneSq     = 33'h1_0000_0000;

  typedef enum logic [CodeW-1:0] {
    CASE_MATCHED = 3'd0,
    CASE_NORMAL  = 3'd1,
    CASE_GRAZING = 3'd2,
    CASE_TIR     = 3'd3,
    CASE_GENERAL = 3'd4
  } case_e;

  // Everything an item carries down the pipeline next to the arithmetic.
  typedef struct packed {
    logic [IdxW-1:0] n1;
    logic [IdxW-1:0] n2;
    logic [IdxW-1:0] dif;
    logic [IdxW:0]   sum;
    logic [CosW-1:0] c1;
    case_e           code;
    logic [CosW-1:0] sa1;
    logic [IdxW-1:0] sa2;
    logic [CosW-1:0] ca2;
    logic            zero1;
    logic            zero2;
  } side_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fresnel_reflectance_core.sv -----
// Channel   Dir  Payload
// s_axis    in   tdata: index_incident, index_transmit, cos_incident
// m_axis    out  tdata: reflectance, cos_transmit; tuser: case_code
//
// One item per cycle enters and leaves while the output is not stalled; the path
// runs through two 17-stage square roots and two 17-stage divider passes in series.
// Reset clears only the valid bits; data registers are not reset.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated;
// the input is ready whenever the output register is empty or being taken.
`timescale 1ns / 1ps
`default_nettype none

`include "fresnel_reflectance_core_macros.svh"

module fresnel_reflectance_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // [15:0] index_incident, [31:16] index_transmit, [48:32] cos_incident
  input  wire logic [frc_pkg::InDataW-1:0]    s_axis_tdata,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [16:0] reflectance, [33:17] cos_transmit
  output logic [frc_pkg::OutDataW-1:0]        m_axis_tdata,
  // [2:0] case_code
  output logic [frc_pkg::OutUserW-1:0]        m_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready
);

  localparam int unsigned IdxW = frc_pkg::IdxW;
  localparam int unsigned CosW = frc_pkg::CosW;
  localparam int unsigned RadW = frc_pkg::RadW;

  logic en;

  // Whole pipeline advances unless the output holds an item that is not taken.
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Stage 1: clamp the cosine and classify the query.
  logic [IdxW-1:0] in_n1, in_n2;
  logic [CosW-1:0] in_c1_raw;
  frc_pkg::side_t  s1_side_d;
  logic            s1_valid_q;
  frc_pkg::side_t  s1_side_q;

  assign in_n1     = s_axis_tdata[15:0];
  assign in_n2     = s_axis_tdata[31:16];
  assign in_c1_raw = s_axis_tdata[48:32];

  always_comb begin
    s1_side_d     = '0;
    s1_side_d.n1  = in_n1;
    s1_side_d.n2  = in_n2;
    s1_side_d.dif = (in_n2 > in_n1) ? in_n2 - in_n1 : in_n1 - in_n2;
    s1_side_d.sum = {1'b0, in_n1} + {1'b0, in_n2};
    s1_side_d.c1  = (in_c1_raw > frc_pkg::FullScale) ? frc_pkg::FullScale : in_c1_raw;
    if (in_n1 == in_n2) begin
      s1_side_d.code = frc_pkg::CASE_MATCHED;
    end else if (s1_side_d.c1 == frc_pkg::FullScale) begin
      s1_side_d.code = frc_pkg::CASE_NORMAL;
    end else if (s1_side_d.c1 == '0) begin
      s1_side_d.code = frc_pkg::CASE_GRAZING;
    end else begin
      s1_side_d.code = frc_pkg::CASE_GENERAL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_side_q <= s1_side_d;
    end
  end

  // Stage 2: radicand 1 - cos^2 for the incident sine.
  logic [2*CosW-1:0] c1_sq;
  logic              s2_valid_q;
  logic [RadW-1:0]   s2_rad_q;
  frc_pkg::side_t    s2_side_q;

  assign c1_sq = s1_side_q.c1 * s1_side_q.c1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_rad_q  <= frc_pkg::OneSq - c1_sq[RadW-1:0];
      s2_side_q <= s1_side_q;
    end
  end

  // Incident sine.
  logic            sq1_valid;
  logic [CosW-1:0] sq1_root;
  frc_pkg::side_t  sq1_side;

  frc_sqrt_pipe u_sqrt_sin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s2_valid_q),
    .rad_i   (s2_rad_q),
    .side_i  (s2_side_q),
    .valid_o (sq1_valid),
    .root_o  (sq1_root),
    .side_o  (sq1_side)
  );

  // Stage 3: Snell product sin1 * n1.
  logic                 s3_valid_q;
  logic [CosW+IdxW-1:0] s3_prod_q;
  frc_pkg::side_t       s3_side_d;
  frc_pkg::side_t       s3_side_q;
  frc_pkg::side_t       s3_side_upd;

  always_comb begin
    s3_side_d     = sq1_side;
    s3_side_d.sa1 = sq1_root;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s3_valid_q <= sq1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_prod_q <= sq1_root * sq1_side.n1;
      s3_side_q <= s3_side_d;
    end
  end

  // The transmitted sine reaches one when sin1 * n1 >= n2; that is total reflection.
  always_comb begin
    s3_side_upd = s3_side_q;
    if (s3_side_q.code == frc_pkg::CASE_GENERAL &&
        (s3_side_q.n2 == '0 || s3_prod_q >= {1'b0, s3_side_q.n2, 16'h0000})) begin
      s3_side_upd.code = frc_pkg::CASE_TIR;
    end
  end

  // Transmitted sine sin1 * n1 / n2.
  logic                    dv1_valid;
  logic [frc_pkg::QuoW-1:0] dv1_quo;
  frc_pkg::side_t          dv1_side;

  frc_div_pipe u_div_snell (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_valid_q),
    .dend_i  (frc_pkg::DendW'(s3_prod_q)),
    .dsor_i  (frc_pkg::DsorW'(s3_side_q.n2)),
    .side_i  (s3_side_upd),
    .valid_o (dv1_valid),
    .quo_o   (dv1_quo),
    .side_o  (dv1_side)
  );

  // Stage 5: radicand 1 - sin2^2.
  logic [2*IdxW-1:0] sa2_sq;
  logic              s5_valid_q;
  logic [RadW-1:0]   s5_rad_q;
  frc_pkg::side_t    s5_side_d;
  frc_pkg::side_t    s5_side_q;

  assign sa2_sq = dv1_quo[IdxW-1:0] * dv1_quo[IdxW-1:0];

  always_comb begin
    s5_side_d     = dv1_side;
    s5_side_d.sa2 = dv1_quo[IdxW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
    end else if (en) begin
      s5_valid_q <= dv1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_rad_q  <= frc_pkg::OneSq - RadW'(sa2_sq);
      s5_side_q <= s5_side_d;
    end
  end

  // Transmitted cosine.
  logic            sq2_valid;
  logic [CosW-1:0] sq2_root;
  frc_pkg::side_t  sq2_side;

  frc_sqrt_pipe u_sqrt_cos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s5_valid_q),
    .rad_i   (s5_rad_q),
    .side_i  (s5_side_q),
    .valid_o (sq2_valid),
    .root_o  (sq2_root),
    .side_o  (sq2_side)
  );

  // Stage 6: angle products, plus the squares for normal incidence.
  logic              s6_valid_q;
  logic [RadW-1:0]   s6_cc_q, s6_ss_q, s6_sc_q, s6_cs_q, s6_dd_q;
  logic [2*CosW-1:0] s6_s2_q;
  frc_pkg::side_t    s6_side_d;
  frc_pkg::side_t    s6_side_q;

  always_comb begin
    s6_side_d     = sq2_side;
    s6_side_d.ca2 = sq2_root;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_valid_q <= 1'b0;
    end else if (en) begin
      s6_valid_q <= sq2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_cc_q   <= RadW'(sq2_side.c1 * sq2_root);
      s6_ss_q   <= RadW'(sq2_side.sa1 * sq2_side.sa2);
      s6_sc_q   <= RadW'(sq2_side.sa1 * sq2_root);
      s6_cs_q   <= RadW'(sq2_side.c1 * sq2_side.sa2);
      s6_dd_q   <= RadW'(sq2_side.dif * sq2_side.dif);
      s6_s2_q   <= sq2_side.sum * sq2_side.sum;
      s6_side_q <= s6_side_d;
    end
  end

  // Stage 7: sums and differences; normal incidence reuses the first ratio.
  localparam int unsigned SumW = frc_pkg::DsorW;

  logic             s7_valid_q;
  logic [SumW-1:0]  s7_num1_q, s7_den1_q, s7_num2_q, s7_den2_q;
  frc_pkg::side_t   s7_side_q;
  logic [SumW-1:0]  sam, sap, cap, cam;

  always_comb begin
    sap = SumW'(s6_sc_q) + SumW'(s6_cs_q);
    sam = (s6_sc_q > s6_cs_q) ? SumW'(s6_sc_q - s6_cs_q) : SumW'(s6_cs_q - s6_sc_q);
    cam = SumW'(s6_cc_q) + SumW'(s6_ss_q);
    cap = (s6_cc_q > s6_ss_q) ? SumW'(s6_cc_q - s6_ss_q) : SumW'(s6_ss_q - s6_cc_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_valid_q <= 1'b0;
    end else if (en) begin
      s7_valid_q <= s6_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (s6_side_q.code == frc_pkg::CASE_NORMAL) begin
        s7_num1_q <= SumW'(s6_dd_q);
        s7_den1_q <= s6_s2_q;
      end else begin
        s7_num1_q <= sam;
        s7_den1_q <= sap;
      end
      s7_num2_q <= cap;
      s7_den2_q <= cam;
      s7_side_q <= s6_side_q;
    end
  end

  // Stage 8: rounded dividends num * 2^16 + den / 2.
  logic                      s8_valid_q;
  logic [frc_pkg::DendW-1:0] s8_dend1_q, s8_dend2_q;
  logic [SumW-1:0]           s8_den1_q, s8_den2_q;
  frc_pkg::side_t            s8_side_d;
  frc_pkg::side_t            s8_side_q;

  always_comb begin
    s8_side_d       = s7_side_q;
    s8_side_d.zero1 = (s7_den1_q == '0);
    s8_side_d.zero2 = (s7_den2_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_valid_q <= 1'b0;
    end else if (en) begin
      s8_valid_q <= s7_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_dend1_q <= (frc_pkg::DendW'(s7_num1_q) << 16) + frc_pkg::DendW'(s7_den1_q >> 1);
      s8_dend2_q <= (frc_pkg::DendW'(s7_num2_q) << 16) + frc_pkg::DendW'(s7_den2_q >> 1);
      s8_den1_q  <= s7_den1_q;
      s8_den2_q  <= s7_den2_q;
      s8_side_q  <= s8_side_d;
    end
  end

  // Sine ratio and cosine ratio, side by side.
  logic                     dv2_valid;
  logic [frc_pkg::QuoW-1:0] dv2_q1, dv2_q2;
  frc_pkg::side_t           dv2_side;

  frc_div_pipe u_div_sin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s8_valid_q),
    .dend_i  (s8_dend1_q),
    .dsor_i  (s8_den1_q),
    .side_i  (s8_side_q),
    .valid_o (dv2_valid),
    .quo_o   (dv2_q1),
    .side_o  (dv2_side)
  );

  frc_div_pipe u_div_cos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s8_valid_q),
    .dend_i  (s8_dend2_q),
    .dsor_i  (s8_den2_q),
    .side_i  (s8_side_q),
    .valid_o (),
    .quo_o   (dv2_q2),
    .side_o  ()
  );

  // Stage 9: squares of the ratios, rounded half up.
  logic [CosW-1:0]   q1, q2;
  logic [2*CosW:0]   q1_sq, q2_sq;
  logic              s9_valid_q;
  logic [CosW-1:0]   s9_q1_q, s9_q1s_q, s9_q2s_q;
  frc_pkg::side_t    s9_side_q;

  always_comb begin
    q1    = dv2_side.zero1 ? frc_pkg::FullScale : dv2_q1;
    q2    = dv2_side.zero2 ? frc_pkg::FullScale : dv2_q2;
    q1_sq = (2*CosW+1)'(q1 * q1) + (2*CosW+1)'(17'h08000);
    q2_sq = (2*CosW+1)'(q2 * q2) + (2*CosW+1)'(17'h08000);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s9_valid_q <= 1'b0;
    end else if (en) begin
      s9_valid_q <= dv2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s9_q1_q   <= q1;
      s9_q1s_q  <= q1_sq[32:16];
      s9_q2s_q  <= q2_sq[32:16];
      s9_side_q <= dv2_side;
    end
  end

  // Stage 10: combine, saturate and pick the result by case.
  logic [2*CosW+1:0] r_full;
  logic [CosW-1:0]   r_gen;
  logic [CosW-1:0]   refl_d, cos_d;
  logic              out_valid_q;
  logic [CosW-1:0]   out_refl_q, out_cos_q;
  frc_pkg::case_e    out_code_q;

  always_comb begin
    r_full = (2*CosW+2)'(s9_q1s_q * ({1'b0, frc_pkg::FullScale} + {1'b0, s9_q2s_q}))
           + (2*CosW+2)'(frc_pkg::FullScale);
    r_gen  = (r_full[2*CosW+1:17] > (2*CosW+1-17)'(frc_pkg::FullScale))
           ? frc_pkg::FullScale : r_full[33:17];
    unique case (s9_side_q.code)
      frc_pkg::CASE_MATCHED: begin
        refl_d = '0;
        cos_d  = s9_side_q.c1;
      end
      frc_pkg::CASE_NORMAL: begin
        refl_d = s9_q1_q;
        cos_d  = frc_pkg::FullScale;
      end
      frc_pkg::CASE_GENERAL: begin
        refl_d = r_gen;
        cos_d  = s9_side_q.ca2;
      end
      default: begin
        refl_d = frc_pkg::FullScale;
        cos_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s9_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_refl_q <= refl_d;
      out_cos_q  <= cos_d;
      out_code_q <= s9_side_q.code;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_cos_q, out_refl_q};
  assign m_axis_tuser  = {5'b0, out_code_q};

  // Checks on the delivered results and on holding items through a stall.
  `FRC_ASSERT_NOW(a_refl_range, m_axis_tvalid, m_axis_tdata[16:0] <= frc_pkg::FullScale && m_axis_tdata[33:17] <= frc_pkg::FullScale, "result out of full scale")
  `FRC_ASSERT_NOW(a_reflect_all, m_axis_tvalid && (out_code_q == frc_pkg::CASE_GRAZING || out_code_q == frc_pkg::CASE_TIR), out_refl_q == frc_pkg::FullScale && out_cos_q == '0, "full reflection case not at full scale")
  `FRC_ASSERT_NOW(a_matched_zero, m_axis_tvalid && out_code_q == frc_pkg::CASE_MATCHED, out_refl_q == '0, "matched indices reflect")
  `FRC_ASSERT_NEXT(a_stall_freeze, s1_valid_q && !en, s1_valid_q, "stalled pipeline dropped an item")

endmodule

`default_nettype wire

// ----- hw/rtl/frc_sqrt_pipe.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Pipelined integer square root, one root bit per stage, most significant first.
module frc_sqrt_pipe (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic                      valid_i,
  input  wire logic [frc_pkg::RadW-1:0]  rad_i,
  input  wire frc_pkg::side_t            side_i,
  output logic                           valid_o,
  output logic [frc_pkg::CosW-1:0]       root_o,
  output frc_pkg::side_t                 side_o
);

  localparam int unsigned N      = frc_pkg::SqStages;
  localparam int unsigned TrialW = frc_pkg::RadW + 2;

  logic                      valid_q [N];
  logic [frc_pkg::RadW-1:0]  rem_q   [N];
  logic [frc_pkg::CosW-1:0]  root_q  [N];
  frc_pkg::side_t            side_q  [N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    localparam int unsigned Bit = N - 1 - g;

    logic                      valid_in;
    logic [frc_pkg::RadW-1:0]  rem_in;
    logic [frc_pkg::CosW-1:0]  root_in;
    frc_pkg::side_t            side_in;
    logic [TrialW-1:0]         trial;
    logic                      fits;
    logic [frc_pkg::RadW-1:0]  rem_d;
    logic [frc_pkg::CosW-1:0]  root_d;

    if (g == 0) begin : g_first
      assign valid_in = valid_i;
      assign rem_in   = rad_i;
      assign root_in  = '0;
      assign side_in  = side_i;
    end else begin : g_next
      assign valid_in = valid_q[g-1];
      assign rem_in   = rem_q[g-1];
      assign root_in  = root_q[g-1];
      assign side_in  = side_q[g-1];
    end

    // (root + 2^Bit)^2 - root^2 = root * 2^(Bit+1) + 2^(2*Bit).
    always_comb begin
      trial  = (TrialW'(root_in) << (Bit + 1)) + (TrialW'(1) << (2 * Bit));
      fits   = TrialW'(rem_in) >= trial;
      rem_d  = fits ? rem_in - trial[frc_pkg::RadW-1:0] : rem_in;
      root_d = fits ? root_in | (frc_pkg::CosW'(1) << Bit) : root_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else if (en_i) begin
        valid_q[g] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= rem_d;
        root_q[g] <= root_d;
        side_q[g] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[N-1];
  assign root_o  = root_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

`default_nettype wire

// ----- hw/rtl/frc_div_pipe.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage. The dividend must be
// below the divisor times 2^17; a zero divisor is flagged and handled outside.
module frc_div_pipe (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic                       valid_i,
  input  wire logic [frc_pkg::DendW-1:0]  dend_i,
  input  wire logic [frc_pkg::DsorW-1:0]  dsor_i,
  input  wire frc_pkg::side_t             side_i,
  output logic                            valid_o,
  output logic [frc_pkg::QuoW-1:0]        quo_o,
  output frc_pkg::side_t                  side_o
);

  localparam int unsigned N = frc_pkg::DivStages;

  logic                       valid_q [N];
  logic [frc_pkg::DendW-1:0]  rem_q   [N];
  logic [frc_pkg::DsorW-1:0]  dsor_q  [N];
  logic [frc_pkg::QuoW-1:0]   quo_q   [N];
  frc_pkg::side_t             side_q  [N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    localparam int unsigned Bit = N - 1 - g;

    logic                       valid_in;
    logic [frc_pkg::DendW-1:0]  rem_in;
    logic [frc_pkg::DsorW-1:0]  dsor_in;
    logic [frc_pkg::QuoW-1:0]   quo_in;
    frc_pkg::side_t             side_in;
    logic [frc_pkg::DendW-1:0]  shifted;
    logic                       fits;

    if (g == 0) begin : g_first
      assign valid_in = valid_i;
      assign rem_in   = dend_i;
      assign dsor_in  = dsor_i;
      assign quo_in   = '0;
      assign side_in  = side_i;
    end else begin : g_next
      assign valid_in = valid_q[g-1];
      assign rem_in   = rem_q[g-1];
      assign dsor_in  = dsor_q[g-1];
      assign quo_in   = quo_q[g-1];
      assign side_in  = side_q[g-1];
    end

    // Subtract the divisor aligned to this quotient bit when it fits.
    always_comb begin
      shifted = frc_pkg::DendW'(dsor_in) << Bit;
      fits    = rem_in >= shifted;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else if (en_i) begin
        valid_q[g] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= fits ? rem_in - shifted : rem_in;
        dsor_q[g] <= dsor_in;
        quo_q[g]  <= fits ? quo_in | (frc_pkg::QuoW'(1) << Bit) : quo_in;
        side_q[g] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[N-1];
  assign quo_o   = quo_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

`default_nettype wire
